// File: rtl/linear_blend_vertex_skinning_assert.svh
// assertion macros shared by the skinning block
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LBVS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbvs assertion failed");

// consequent must hold in the cycle after the antecedent
`define LBVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbvs assertion failed");

`endif

// File: rtl/lbvs_pkg.sv
// types, codes and fixed-point helpers for the skinning block
`timescale 1ns / 1ps

package lbvs_pkg;

    // input item function codes
    localparam logic [1:0] FUNC_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ID     = 2'd1;
    localparam logic [1:0] FUNC_SKIN        = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam int         CFG_DATA_W     = 6;
    localparam logic [0:0] CFG_SLOT_COUNT = 1'd0;
    localparam logic [0:0] CFG_ANIM_FRAME = 1'd1;

    // matrix words per bone and frame (3 rows by 4 columns)
    localparam int MAT_WORDS = 12;

    // weight of 1.0 in Q1.16 and match counter ceiling
    localparam logic [16:0] W_ONE   = 17'h10000;
    localparam logic [3:0]  CNT_MAX = 4'd15;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         frame;
        logic [4:0]         bone_slot;
        logic [3:0]         element;
        logic signed [31:0] value;
        logic [7:0]         bone_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [16:0]        weight;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic [3:0]         bones_matched;
        logic               saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_RD,
        S_MUL,
        S_ADD,
        S_CLIP,
        S_WMUL,
        S_WADD,
        S_FINISH,
        S_EMIT
    } t_state;

    // datapath controls driven by the sequencer
    typedef struct packed {
        logic       mul;
        logic       add;
        logic       clip;
        logic       wmul;
        logic       wadd;
        logic       clear;
        logic [1:0] row;
        logic [1:0] col;
    } t_dp_ctl;

    // true when a value falls outside the signed 32-bit range
    function automatic logic ovf32(input logic signed [63:0] v);
        logic hi;
        logic lo;
        hi = (v > 64'sd2147483647);
        lo = (v < -64'sd2147483648);
        return hi | lo;
    endfunction

    // clip to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/lbvs_xform.sv
// row transform, weight scaling and saturating accumulators
`timescale 1ns / 1ps

module lbvs_xform (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lbvs_pkg::t_dp_ctl     i_ctl,
    input  logic signed [31:0]    i_mem_q,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic [16:0]           i_weight,
    output logic signed [31:0]    o_acc_x,
    output logic signed [31:0]    o_acc_y,
    output logic signed [31:0]    o_acc_z,
    output logic                  o_clip
);

    logic signed [63:0] r_prod;
    logic signed [49:0] r_t;
    logic signed [31:0] r_tc;
    logic signed [31:0] r_acc [3];
    logic               r_clip;

    logic signed [31:0] pos_sel;
    logic signed [31:0] acc_sel;
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] prod_full;
    logic signed [63:0] term;
    logic signed [49:0] n_t;
    logic signed [63:0] t_wide;
    logic signed [63:0] acc_sum;

    // operand selection for the shared multiplier
    always_comb begin
        case (i_ctl.col)
            2'd0:    pos_sel = i_pos_x;
            2'd1:    pos_sel = i_pos_y;
            default: pos_sel = i_pos_z;
        endcase
        case (i_ctl.row)
            2'd0:    acc_sel = r_acc[0];
            2'd1:    acc_sel = r_acc[1];
            default: acc_sel = r_acc[2];
        endcase
        mul_a = i_ctl.wmul ? r_tc : pos_sel;
        mul_b = i_ctl.wmul ? $signed({16'd0, i_weight}) : $signed({i_mem_q[31], i_mem_q});
    end

    assign prod_full = mul_a * mul_b;

    // floor of the product over 2^16, row sum and accumulator sum
    assign term    = r_prod >>> 16;
    assign n_t     = ((i_ctl.col == 2'd0) ? 50'sd0 : r_t) + term[49:0];
    assign t_wide  = {{14{r_t[49]}}, r_t};
    assign acc_sum = {{32{acc_sel[31]}}, acc_sel} + term;

    // product register; translation words enter as m * 2^16
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            if (i_ctl.col == 2'd3) begin
                r_prod <= {{16{i_mem_q[31]}}, i_mem_q, 16'd0};
            end else begin
                r_prod <= prod_full[63:0];
            end
        end else if (i_ctl.wmul) begin
            r_prod <= prod_full[63:0];
        end
    end

    // row sum and its clipped value
    always_ff @(posedge i_clk) begin
        if (i_ctl.add) begin
            r_t <= n_t;
        end
        if (i_ctl.clip) begin
            r_tc <= lbvs_pkg::sat32(t_wide);
        end
    end

    // accumulators and clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_clip   <= 1'b0;
        end else begin
            if (i_ctl.clip && lbvs_pkg::ovf32(t_wide)) begin
                r_clip <= 1'b1;
            end
            if (i_ctl.wadd) begin
                for (int k = 0; k < 3; k++) begin
                    if (i_ctl.row == 2'(k)) begin
                        r_acc[k] <= lbvs_pkg::sat32(acc_sum);
                    end
                end
                if (lbvs_pkg::ovf32(acc_sum)) begin
                    r_clip <= 1'b1;
                end
            end
        end
    end

    assign o_acc_x = r_acc[0];
    assign o_acc_y = r_acc[1];
    assign o_acc_z = r_acc[2];
    assign o_clip  = r_clip;

endmodule

// File: rtl/linear_blend_vertex_skinning.sv
// Linear blend vertex skinning: a skin item with a found bone runs accept, compare,
// encode, 3 rows of 4 matrix words (read, mul, add) plus weighting (clip, mul, add),
// then finish; an unmatched one skips the rows, a zero-weight one skips to finish. A
// last item adds an emit step to load the result register, which parts the sides.
// Rate is set by the single matrix memory read port and the one shared multiplier.
// Synchronous active-low reset clears config, accumulators, count and control.
`timescale 1ns / 1ps
`include "linear_blend_vertex_skinning_assert.svh"

module linear_blend_vertex_skinning #(
    parameter int MAX_BONES  = 32,
    parameter int MAX_FRAMES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  lbvs_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lbvs_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_we,
    input  logic [lbvs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lbvs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int L_DEPTH = MAX_BONES * MAX_FRAMES * lbvs_pkg::MAT_WORDS;
    localparam int AW      = $clog2(L_DEPTH);
    localparam int SW      = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int FW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [AW-1:0] L_FRAMES_A = AW'(MAX_FRAMES);
    localparam logic [AW-1:0] L_WORDS_A  = AW'(lbvs_pkg::MAT_WORDS);

    lbvs_pkg::t_state    r_state;
    lbvs_pkg::t_state    n_state;
    lbvs_pkg::t_dp_ctl   dp_ctl;
    lbvs_pkg::t_out_item r_out;

    logic [5:0]           r_slot_count;
    logic [2:0]           r_anim_frame;
    logic signed [31:0]   r_mat_mem [L_DEPTH];
    logic signed [31:0]   r_mem_q;
    logic [7:0]           r_slot_ids [MAX_BONES];
    logic [MAX_BONES-1:0] r_hit;
    logic [AW-1:0]        r_base;
    logic [1:0]           r_row;
    logic [1:0]           r_col;
    logic                 r_matched;
    logic [3:0]           r_match_cnt;
    logic                 r_out_valid;
    logic [7:0]           r_id;
    logic signed [31:0]   r_pos_x;
    logic signed [31:0]   r_pos_y;
    logic signed [31:0]   r_pos_z;
    logic [16:0]          r_weight;
    logic                 r_last;

    logic                 in_acc;
    logic                 mat_we;
    logic                 id_we;
    logic                 skin_go;
    logic                 emit_go;
    logic [16:0]          w_sat;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [3:0]           rd_elem;
    logic [MAX_BONES-1:0] hit;
    logic [SW-1:0]        enc;
    logic [FW-1:0]        fr_sel;
    logic signed [31:0]   acc_x;
    logic signed [31:0]   acc_y;
    logic signed [31:0]   acc_z;
    logic                 clip;

    // input handshake and item decode
    assign o_stall = (r_state != lbvs_pkg::S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign mat_we  = in_acc && (i_item.func == lbvs_pkg::FUNC_LOAD_MATRIX)
                     && (32'(i_item.frame) < MAX_FRAMES)
                     && (32'(i_item.bone_slot) < MAX_BONES)
                     && (32'(i_item.element) < lbvs_pkg::MAT_WORDS);
    assign id_we   = in_acc && (i_item.func == lbvs_pkg::FUNC_LOAD_ID)
                     && (32'(i_item.bone_slot) < MAX_BONES);
    assign skin_go = in_acc && (i_item.func == lbvs_pkg::FUNC_SKIN);
    assign w_sat   = (i_item.weight > lbvs_pkg::W_ONE) ? lbvs_pkg::W_ONE : i_item.weight;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_anim_frame <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lbvs_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[5:0];
                lbvs_pkg::CFG_ANIM_FRAME: r_anim_frame <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // frame clamp and matrix memory addresses
    assign fr_sel  = (32'(r_anim_frame) < MAX_FRAMES) ? FW'(r_anim_frame) : FW'(MAX_FRAMES - 1);
    assign wr_addr = (AW'(i_item.bone_slot) * L_FRAMES_A + AW'(i_item.frame)) * L_WORDS_A
                     + AW'(i_item.element);
    assign rd_elem = 4'(r_col) * 4'd3 + 4'(r_row);
    assign rd_addr = r_base + AW'(rd_elem);

    // matrix memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat_mem[wr_addr] <= i_item.value;
        end
        r_mem_q <= r_mat_mem[rd_addr];
    end

    // slot bone ids
    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_slot_ids[SW'(i_item.bone_slot)] <= i_item.value[7:0];
        end
    end

    // slot compare over the loaded slots
    always_comb begin
        for (int s = 0; s < MAX_BONES; s++) begin
            hit[s] = (s < 32'(r_slot_count)) && (r_slot_ids[s] == r_id);
        end
    end

    // first matching slot
    always_comb begin
        enc = '0;
        for (int s = MAX_BONES - 1; s >= 0; s--) begin
            if (r_hit[s]) begin
                enc = SW'(s);
            end
        end
    end

    // captured skin item
    always_ff @(posedge i_clk) begin
        if (skin_go) begin
            r_id     <= i_item.bone_id;
            r_pos_x  <= i_item.pos_x;
            r_pos_y  <= i_item.pos_y;
            r_pos_z  <= i_item.pos_z;
            r_weight <= w_sat;
            r_last   <= i_item.last;
        end
        if (r_state == lbvs_pkg::S_CMP) begin
            r_hit <= hit;
        end
        if (r_state == lbvs_pkg::S_ENC) begin
            r_base <= (AW'(enc) * L_FRAMES_A + AW'(fr_sel)) * L_WORDS_A;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbvs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and datapath controls
    always_comb begin
        n_state    = r_state;
        dp_ctl     = '0;
        dp_ctl.row = r_row;
        dp_ctl.col = r_col;
        emit_go    = 1'b0;
        case (r_state)
            lbvs_pkg::S_IDLE: begin
                if (skin_go) begin
                    n_state = (w_sat == '0) ? lbvs_pkg::S_FINISH : lbvs_pkg::S_CMP;
                end
            end
            lbvs_pkg::S_CMP: begin
                n_state = lbvs_pkg::S_ENC;
            end
            lbvs_pkg::S_ENC: begin
                n_state = (|r_hit) ? lbvs_pkg::S_RD : lbvs_pkg::S_FINISH;
            end
            lbvs_pkg::S_RD: begin
                n_state = lbvs_pkg::S_MUL;
            end
            lbvs_pkg::S_MUL: begin
                dp_ctl.mul = 1'b1;
                n_state    = lbvs_pkg::S_ADD;
            end
            lbvs_pkg::S_ADD: begin
                dp_ctl.add = 1'b1;
                n_state    = (r_col == 2'd3) ? lbvs_pkg::S_CLIP : lbvs_pkg::S_RD;
            end
            lbvs_pkg::S_CLIP: begin
                dp_ctl.clip = 1'b1;
                n_state     = lbvs_pkg::S_WMUL;
            end
            lbvs_pkg::S_WMUL: begin
                dp_ctl.wmul = 1'b1;
                n_state     = lbvs_pkg::S_WADD;
            end
            lbvs_pkg::S_WADD: begin
                dp_ctl.wadd = 1'b1;
                n_state     = (r_row == 2'd2) ? lbvs_pkg::S_FINISH : lbvs_pkg::S_RD;
            end
            lbvs_pkg::S_FINISH: begin
                n_state = r_last ? lbvs_pkg::S_EMIT : lbvs_pkg::S_IDLE;
            end
            lbvs_pkg::S_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    emit_go      = 1'b1;
                    dp_ctl.clear = 1'b1;
                    n_state      = lbvs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lbvs_pkg::S_IDLE;
            end
        endcase
    end

    // row and column counters, match tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_matched   <= 1'b0;
            r_match_cnt <= '0;
        end else begin
            if (skin_go) begin
                r_matched <= 1'b0;
            end
            case (r_state)
                lbvs_pkg::S_ENC: begin
                    r_row     <= '0;
                    r_col     <= '0;
                    r_matched <= |r_hit;
                end
                lbvs_pkg::S_ADD: begin
                    r_col <= (r_col == 2'd3) ? 2'd0 : r_col + 2'd1;
                end
                lbvs_pkg::S_WADD: begin
                    if (r_row != 2'd2) begin
                        r_row <= r_row + 2'd1;
                    end
                end
                lbvs_pkg::S_FINISH: begin
                    if (r_matched && (r_match_cnt != lbvs_pkg::CNT_MAX)) begin
                        r_match_cnt <= r_match_cnt + 4'd1;
                    end
                end
                lbvs_pkg::S_EMIT: begin
                    if (emit_go) begin
                        r_match_cnt <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    lbvs_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (dp_ctl),
        .i_mem_q  (r_mem_q),
        .i_pos_x  (r_pos_x),
        .i_pos_y  (r_pos_y),
        .i_pos_z  (r_pos_z),
        .i_weight (r_weight),
        .o_acc_x  (acc_x),
        .o_acc_y  (acc_y),
        .o_acc_z  (acc_z),
        .o_clip   (clip)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out.skinned_x     <= acc_x;
            r_out.skinned_y     <= acc_y;
            r_out.skinned_z     <= acc_z;
            r_out.bones_matched <= r_match_cnt;
            r_out.saturated     <= clip;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // emitting fills the result register and returns to idle
    `LBVS_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, emit_go, r_out_valid && r_state == lbvs_pkg::S_IDLE)
    // the matched-bone count restarts after each result
    `LBVS_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, emit_go, r_match_cnt == 4'd0)
    // a multiply always follows its memory read
    `LBVS_ASSERT_SAME(a_mul_after_rd, i_clk, i_rst_n, r_state == lbvs_pkg::S_MUL, $past(r_state) == lbvs_pkg::S_RD)
    // a zero-weight item skips the search and the matrix
    `LBVS_ASSERT_NEXT(a_zero_weight, i_clk, i_rst_n, skin_go && i_item.weight == 17'd0, r_state == lbvs_pkg::S_FINISH)

endmodule
